FILE: design/rrtt_pkg.sv
// ----------------------------------------------------------------------------
// rrtt_pkg
// Shared types, codes and defaults of the request retry timeout tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrtt_pkg;

  localparam int unsigned PoolSlotsDef = 32;

  // function codes
  localparam logic [2:0] FN_ALLOC  = 3'd0;
  localparam logic [2:0] FN_RESP   = 3'd1;
  localparam logic [2:0] FN_ERR    = 3'd2;
  localparam logic [2:0] FN_AGE    = 3'd3;
  localparam logic [2:0] FN_RETIRE = 3'd4;

  // result codes
  localparam logic [2:0] EV_ALLOC    = 3'd0;
  localparam logic [2:0] EV_FULL     = 3'd1;
  localparam logic [2:0] EV_RELEASED = 3'd2;
  localparam logic [2:0] EV_NOTFOUND = 3'd3;
  localparam logic [2:0] EV_RESEND   = 3'd4;
  localparam logic [2:0] EV_EXPIRED  = 3'd5;
  localparam logic [2:0] EV_RETIRED  = 3'd6;
  localparam logic [2:0] EV_DONE     = 3'd7;

  // register indexes
  localparam logic [2:0] REG_INIT_TMO = 3'd0;
  localparam logic [2:0] REG_LIMIT    = 3'd1;
  localparam logic [2:0] REG_STEP     = 3'd2;
  localparam logic [2:0] REG_BUDGET   = 3'd3;
  localparam logic [2:0] REG_SLACK    = 3'd4;
  localparam logic [2:0] REG_MASK     = 3'd5;

  typedef struct packed {
    logic        live;
    logic [23:0] lid;
    logic [63:0] tid;
    logic [47:0] stamp;
    logic [31:0] tmo;
    logic [7:0]  tries;
    logic [33:0] spent;
  } entry_t;

  typedef struct packed {
    logic [31:0] init_tmo;
    logic [7:0]  retry_limit;
    logic [31:0] step_tmo;
    logic [31:0] budget;
    logic [31:0] slack;
    logic [63:0] mask;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [23:0] lid;
    logic [63:0] tid;
    logic [47:0] now;
    logic [4:0]  sel;
  } cmd_t;

  typedef struct packed {
    entry_t      nxt;
    logic        hit;
    logic        emit;
    logic [2:0]  ev;
    logic        left_vld;
    logic [32:0] left;
  } head_t;

endpackage

`default_nettype wire

FILE: design/rrtt_cell.sv
// ----------------------------------------------------------------------------
// rrtt_cell
// One slot of the ring; takes its neighbor's entry on every ring step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrtt_cell
  import rrtt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   shift_i,
  input  wire entry_t entry_i,
  output entry_t      entry_o
);

  logic   live_q;
  entry_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (shift_i) begin
      live_q <= entry_i.live;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= entry_i;
    end
  end

  always_comb begin
    entry_o      = data_q;
    entry_o.live = live_q;
  end

endmodule

`default_nettype wire

FILE: design/rrtt_head.sv
// ----------------------------------------------------------------------------
// rrtt_head
// Work on the entry at the head of the ring: match, allocate, release, retry, retire, age.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrtt_head
  import rrtt_pkg::*;
(
  input  wire entry_t head_i,
  input  wire cmd_t   cmd_i,
  input  wire cfg_t   cfg_i,
  input  wire logic   found_i,
  input  wire logic   sel_hit_i,
  output head_t       res_o
);

  logic        match;
  logic [33:0] spent_n;
  logic [8:0]  tries_p1;
  logic [40:0] t_mul;
  logic [40:0] t_sel;
  logic [33:0] diff;
  logic        in_budget;
  logic [31:0] tmo_n;
  logic        stepped;
  logic        resend;
  entry_t      retried;
  entry_t      fresh;
  logic [47:0] elapsed;
  logic [32:0] limit;
  logic        overdue;

  always_comb begin
    match = head_i.live && (head_i.lid == cmd_i.lid) &&
            ((head_i.tid & cfg_i.mask) == (cmd_i.tid & cfg_i.mask));

    // retry step
    spent_n   = head_i.spent + 34'(head_i.tmo);
    tries_p1  = {1'b0, head_i.tries} + 9'd1;
    t_mul     = 41'(tries_p1) * 41'(cfg_i.step_tmo);
    in_budget = spent_n < 34'(cfg_i.budget);
    diff      = 34'(cfg_i.budget) - spent_n;
    t_sel     = t_mul;
    if (in_budget && ((42'(spent_n) + 42'(t_mul)) > 42'(cfg_i.budget))) begin
      t_sel = (diff < 34'(cfg_i.step_tmo)) ? 41'(cfg_i.step_tmo) : 41'(diff);
    end
    tmo_n   = (t_sel > 41'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : t_sel[31:0];
    stepped = cfg_i.step_tmo != 32'd0;
    resend  = stepped ? in_budget : (head_i.tries < cfg_i.retry_limit);

    retried       = head_i;
    retried.stamp = cmd_i.now;
    if (stepped) begin
      retried.spent = spent_n;
      retried.tmo   = tmo_n;
    end
    if (resend && (head_i.tries != 8'hFF)) begin
      retried.tries = head_i.tries + 8'd1;
    end
    retried.live = resend;

    fresh.live  = 1'b1;
    fresh.lid   = cmd_i.lid;
    fresh.tid   = cmd_i.tid;
    fresh.stamp = cmd_i.now;
    fresh.tmo   = cfg_i.init_tmo;
    fresh.tries = 8'd0;
    fresh.spent = 34'd0;

    elapsed = cmd_i.now - head_i.stamp;
    limit   = 33'(head_i.tmo) + 33'(cfg_i.slack);
    overdue = elapsed >= 48'(limit);

    res_o          = '0;
    res_o.nxt      = head_i;
    res_o.ev       = resend ? EV_RESEND : EV_EXPIRED;
    case (cmd_i.func)
      FN_ALLOC: begin
        res_o.ev = EV_ALLOC;
        if (!found_i && !head_i.live) begin
          res_o.nxt = fresh;
          res_o.hit = 1'b1;
        end
      end
      FN_RESP: begin
        res_o.ev = EV_RELEASED;
        if (!found_i && match) begin
          res_o.nxt.live = 1'b0;
          res_o.hit      = 1'b1;
        end
      end
      FN_ERR: begin
        if (!found_i && match) begin
          res_o.nxt = retried;
          res_o.hit = 1'b1;
        end
      end
      FN_RETIRE: begin
        res_o.ev = EV_RETIRED;
        if (sel_hit_i && head_i.live) begin
          res_o.nxt.live = 1'b0;
          res_o.hit      = 1'b1;
        end
      end
      FN_AGE: begin
        if (head_i.live) begin
          if (overdue) begin
            res_o.nxt      = retried;
            res_o.emit     = 1'b1;
            res_o.left_vld = resend;
            res_o.left     = 33'(retried.tmo) + 33'(cfg_i.slack);
          end else begin
            res_o.left_vld = 1'b1;
            res_o.left     = limit - elapsed[32:0];
          end
        end
      end
      default: begin
        res_o.hit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/request_retry_timeout_tracker.sv
// ----------------------------------------------------------------------------
// request_retry_timeout_tracker
// Outstanding request table with retry and timeout, kept in a ring of cells.
// ----------------------------------------------------------------------------
// Commands come in on the s_axis stream (tuser holds the function code),
// results leave on the m_axis stream (tuser holds the event code, tlast marks
// the final result of a command). Registers are written over the APB port.
// The slots sit in a ring of POOL_SLOTS cells that rotates one slot per
// cycle past a single head unit while the receiver does not stall, so
// every command with a used function code takes one full turn of the
// ring, and then its final result is loaded. An age scan emits one
// result for each overdue slot as it passes the head and then a scan-done
// result. Unused function codes are accepted and dropped at once. While the
// receiver stalls, the ring holds and no new command is taken until the
// final result has been loaded. The next command is taken in the cycle after
// the final result is loaded. Reset frees all slots and sets the registers to
// their defaults; slot contents are written on allocation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module request_retry_timeout_tracker
  import rrtt_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = PoolSlotsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // peer_lid[23:0], trans_id[87:24], now[135:88], slot_sel[140:136]
  input  wire logic [143:0] s_axis_tdata,
  // func[2:0]
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // slot[4:0], lid_out[28:5], tid_out[92:29], attempt[100:93],
  // next_deadline[133:101]
  output logic [135:0]      m_axis_tdata,
  // event_res[2:0]
  output logic [2:0]        m_axis_tuser,
  output logic              m_axis_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  localparam int unsigned CW = $clog2(POOL_SLOTS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_e;

  state_e      state_q;
  cfg_t        cfg_q;
  cmd_t        cmd_q;
  logic [CW-1:0] cnt_q;
  logic        found_q;
  logic        have_q;
  logic [32:0] best_q;
  logic [2:0]  hold_ev_q;
  logic [4:0]  hold_slot_q;
  logic [23:0] hold_lid_q;
  logic [63:0] hold_tid_q;
  logic [7:0]  hold_tries_q;

  logic        out_vld_q;
  logic [2:0]  out_ev_q;
  logic [4:0]  out_slot_q;
  logic [23:0] out_lid_q;
  logic [63:0] out_tid_q;
  logic [7:0]  out_att_q;
  logic [32:0] out_dl_q;
  logic        out_last_q;

  entry_t      cell_q [POOL_SLOTS];
  entry_t      cell_d [POOL_SLOTS];
  head_t       head;
  logic        out_free;
  logic        out_load;
  logic        step;
  logic        sel_hit;
  logic        cfg_wr;

  assign out_free = !out_vld_q || m_axis_tready;
  assign step     = (state_q == ST_RUN) && out_free;
  assign out_load = (step && head.emit) || ((state_q == ST_DONE) && out_free);
  assign sel_hit  = 32'(cmd_q.sel) == 32'(cnt_q);
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;

  rrtt_head u_head (
    .head_i    (cell_q[0]),
    .cmd_i     (cmd_q),
    .cfg_i     (cfg_q),
    .found_i   (found_q),
    .sel_hit_i (sel_hit),
    .res_o     (head)
  );

  for (genvar k = 0; k < POOL_SLOTS; k++) begin : g_cell
    if (k == POOL_SLOTS - 1) begin : g_tail
      assign cell_d[k] = head.nxt;
    end else begin : g_mid
      assign cell_d[k] = cell_q[k+1];
    end
    rrtt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (step),
      .entry_i (cell_d[k]),
      .entry_o (cell_q[k])
    );
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_tmo    <= 32'd0;
      cfg_q.retry_limit <= 8'd3;
      cfg_q.step_tmo    <= 32'd0;
      cfg_q.budget      <= 32'd0;
      cfg_q.slack       <= 32'd0;
      cfg_q.mask        <= '1;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        REG_INIT_TMO: cfg_q.init_tmo    <= pwdata[31:0];
        REG_LIMIT:    cfg_q.retry_limit <= pwdata[7:0];
        REG_STEP:     cfg_q.step_tmo    <= pwdata[31:0];
        REG_BUDGET:   cfg_q.budget      <= pwdata[31:0];
        REG_SLACK:    cfg_q.slack       <= pwdata[31:0];
        REG_MASK:     cfg_q.mask        <= pwdata;
        default:      cfg_q.mask        <= cfg_q.mask;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_INIT_TMO: prdata = 64'(cfg_q.init_tmo);
      REG_LIMIT:    prdata = 64'(cfg_q.retry_limit);
      REG_STEP:     prdata = 64'(cfg_q.step_tmo);
      REG_BUDGET:   prdata = 64'(cfg_q.budget);
      REG_SLACK:    prdata = 64'(cfg_q.slack);
      REG_MASK:     prdata = cfg_q.mask;
      default:      prdata = 64'd0;
    endcase
  end

  assign s_axis_tready = state_q == ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      have_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && m_axis_tready && !out_load) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q.func <= s_axis_tuser;
            cmd_q.lid  <= s_axis_tdata[23:0];
            cmd_q.tid  <= s_axis_tdata[87:24];
            cmd_q.now  <= s_axis_tdata[135:88];
            cmd_q.sel  <= s_axis_tdata[140:136];
            cnt_q      <= '0;
            found_q    <= 1'b0;
            have_q     <= 1'b0;
            // unused function codes are dropped
            if (s_axis_tuser <= FN_RETIRE) begin
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (step) begin
            cnt_q <= cnt_q + CW'(1);
            if (cnt_q == CW'(POOL_SLOTS - 1)) begin
              state_q <= ST_DONE;
            end
            if (head.hit) begin
              found_q      <= 1'b1;
              hold_ev_q    <= head.ev;
              hold_slot_q  <= 5'(cnt_q);
              hold_lid_q   <= head.nxt.lid;
              hold_tid_q   <= head.nxt.tid;
              hold_tries_q <= head.nxt.tries;
            end
            if (head.left_vld && (!have_q || (head.left < best_q))) begin
              have_q <= 1'b1;
              best_q <= head.left;
            end
            if (head.emit) begin
              out_vld_q  <= 1'b1;
              out_ev_q   <= head.ev;
              out_slot_q <= 5'(cnt_q);
              out_lid_q  <= head.nxt.lid;
              out_tid_q  <= head.nxt.tid;
              out_att_q  <= head.nxt.tries;
              out_dl_q   <= 33'd0;
              out_last_q <= 1'b0;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_last_q <= 1'b1;
            if ((cmd_q.func != FN_AGE) && found_q) begin
              out_ev_q   <= hold_ev_q;
              out_slot_q <= hold_slot_q;
              out_lid_q  <= hold_lid_q;
              out_tid_q  <= hold_tid_q;
              out_att_q  <= hold_tries_q;
            end else begin
              out_slot_q <= 5'd0;
              out_lid_q  <= 24'd0;
              out_tid_q  <= 64'd0;
              out_att_q  <= 8'd0;
              if (cmd_q.func == FN_AGE) begin
                out_ev_q <= EV_DONE;
              end else if (cmd_q.func == FN_ALLOC) begin
                out_ev_q <= EV_FULL;
              end else begin
                out_ev_q <= EV_NOTFOUND;
              end
            end
            out_dl_q <= ((cmd_q.func == FN_AGE) && have_q) ? best_q : 33'd0;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_ev_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_dl_q, out_att_q, out_tid_q, out_lid_q, out_slot_q};

endmodule

`default_nettype wire

FILE: design/rrtt_checker.sv
// ----------------------------------------------------------------------------
// rrtt_checker
// Port-level checks of the request retry timeout tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrtt_checker
  import rrtt_pkg::*;
(
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [2:0]   s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [135:0] m_axis_tdata,
  input wire logic [2:0]   m_axis_tuser,
  input wire logic         m_axis_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a real command blocks the input once it has been taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser <= FN_RETIRE) |=>
      !s_axis_tready)
    else $error("command taken while busy");

  // scan done is always the final result
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_DONE) |-> m_axis_tlast)
    else $error("scan done without last");

  // only age events come before the final result
  a_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |->
      (m_axis_tuser == EV_RESEND) || (m_axis_tuser == EV_EXPIRED))
    else $error("unexpected intermediate event");

  // deadline only on scan done
  a_dl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != EV_DONE) |-> (m_axis_tdata[133:101] == 33'd0))
    else $error("deadline on non scan event");

endmodule

bind request_retry_timeout_tracker rrtt_checker u_rrtt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: verif/tb_request_retry_timeout_tracker.sv
// ----------------------------------------------------------------------------
// tb_request_retry_timeout_tracker
// Self-checking testbench of the outstanding request table.
// ----------------------------------------------------------------------------
// Commands go in on the s_axis stream with random gaps. A scoreboard keeps
// its own copy of the slot table and registers, and predicts the results of
// every accepted command. Each m_axis result is compared field by field with
// the oldest prediction, while the receiver stalls at random. Registers are
// reprogrammed over APB between phases: fixed retry mode, stepped timeouts,
// masked tid compares and extreme values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_request_retry_timeout_tracker;
  import rrtt_pkg::*;

  localparam int unsigned NumSlots = 32;
  localparam int unsigned StallLimit = 4000;

  typedef struct {
    logic [2:0]  ev;
    logic [4:0]  slot;
    logic [23:0] lid;
    logic [63:0] tid;
    logic [7:0]  att;
    logic [32:0] dl;
    logic        last;
  } result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [5:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  request_retry_timeout_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // register shadow
  logic [31:0] cfg_init_tmo = 32'd0;
  logic [7:0]  cfg_limit = 8'd3;
  logic [31:0] cfg_step = 32'd0;
  logic [31:0] cfg_budget = 32'd0;
  logic [31:0] cfg_slack = 32'd0;
  logic [63:0] cfg_mask = '1;

  // slot table shadow
  bit          tbl_live [NumSlots];
  logic [23:0] tbl_lid [NumSlots];
  logic [63:0] tbl_tid [NumSlots];
  logic [47:0] tbl_stamp [NumSlots];
  logic [31:0] tbl_wait [NumSlots];
  logic [7:0]  tbl_tries [NumSlots];
  logic [63:0] tbl_spent [NumSlots];

  result_t     pending_results[$];
  int          err_count = 0;
  int          stall_cycles = 0;
  bit          sink_busy = 1'b1;
  logic [47:0] cur_now = '0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver stalls
  int sink_hold = 0;
  always @(negedge clk_i) begin
    if (sink_busy && sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      sink_hold = sink_busy ? draw_gap() : 0;
    end
  end

  function automatic result_t slot_result(logic [2:0] ev, int s, logic lst);
    result_t r;
    r.ev = ev;
    r.slot = s[4:0];
    r.lid = tbl_lid[s];
    r.tid = tbl_tid[s];
    r.att = tbl_tries[s];
    r.dl = '0;
    r.last = lst;
    return r;
  endfunction

  function automatic result_t blank_result(logic [2:0] ev, logic [32:0] dl);
    result_t r;
    r.ev = ev;
    r.slot = '0;
    r.lid = '0;
    r.tid = '0;
    r.att = '0;
    r.dl = dl;
    r.last = 1'b1;
    return r;
  endfunction

  // retry step on slot s; returns 1 when the slot expires
  function automatic bit retry_slot(int s, logic [47:0] now);
    logic [63:0] spent;
    logic [63:0] nxt;
    bit          resend;
    tbl_stamp[s] = now;
    if (cfg_step != 0) begin
      spent = tbl_spent[s] + 64'(tbl_wait[s]);
      nxt = (64'(tbl_tries[s]) + 64'd1) * 64'(cfg_step);
      if (spent < 64'(cfg_budget) && spent + nxt > 64'(cfg_budget)) begin
        nxt = 64'(cfg_budget) - spent;
        if (nxt < 64'(cfg_step)) nxt = 64'(cfg_step);
      end
      tbl_spent[s] = spent;
      tbl_wait[s] = (nxt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
      resend = spent < 64'(cfg_budget);
    end else begin
      resend = tbl_tries[s] < cfg_limit;
    end
    if (resend) begin
      if (tbl_tries[s] != 8'hFF) tbl_tries[s]++;
      return 1'b0;
    end
    tbl_live[s] = 1'b0;
    return 1'b1;
  endfunction

  function automatic int lookup_slot(logic [23:0] lid, logic [63:0] tid);
    for (int i = 0; i < NumSlots; i++)
      if (tbl_live[i] && tbl_lid[i] == lid && (tbl_tid[i] & cfg_mask) == (tid & cfg_mask))
        return i;
    return -1;
  endfunction

  task automatic predict_results(logic [2:0] fn, logic [23:0] lid, logic [63:0] tid,
                                 logic [47:0] now, logic [4:0] sel);
    int          idx;
    bit          gone;
    bit          have;
    logic [63:0] best;
    logic [63:0] lim;
    logic [63:0] elapsed;
    idx = -1;
    have = 1'b0;
    best = '0;
    case (fn)
      FN_ALLOC: begin
        for (int i = 0; i < NumSlots && idx < 0; i++) if (!tbl_live[i]) idx = i;
        if (idx < 0) begin
          pending_results.push_back(blank_result(EV_FULL, '0));
        end else begin
          tbl_live[idx] = 1'b1;
          tbl_lid[idx] = lid;
          tbl_tid[idx] = tid;
          tbl_stamp[idx] = now;
          tbl_wait[idx] = cfg_init_tmo;
          tbl_tries[idx] = '0;
          tbl_spent[idx] = '0;
          pending_results.push_back(slot_result(EV_ALLOC, idx, 1'b1));
        end
      end
      FN_RESP, FN_ERR: begin
        idx = lookup_slot(lid, tid);
        if (idx < 0) begin
          pending_results.push_back(blank_result(EV_NOTFOUND, '0));
        end else if (fn == FN_RESP) begin
          tbl_live[idx] = 1'b0;
          pending_results.push_back(slot_result(EV_RELEASED, idx, 1'b1));
        end else begin
          gone = retry_slot(idx, now);
          pending_results.push_back(slot_result(gone ? EV_EXPIRED : EV_RESEND, idx, 1'b1));
        end
      end
      FN_AGE: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (tbl_live[i]) begin
            lim = 64'(tbl_wait[i]) + 64'(cfg_slack);
            elapsed = 64'(48'(now - tbl_stamp[i]));
            gone = 1'b0;
            if (elapsed >= lim) begin
              gone = retry_slot(i, now);
              pending_results.push_back(slot_result(gone ? EV_EXPIRED : EV_RESEND, i, 1'b0));
              lim = 64'(tbl_wait[i]) + 64'(cfg_slack);
              elapsed = '0;
            end
            if (!gone && (!have || lim - elapsed < best)) begin
              best = lim - elapsed;
              have = 1'b1;
            end
          end
        end
        pending_results.push_back(blank_result(EV_DONE, best[32:0]));
      end
      FN_RETIRE: begin
        if (tbl_live[sel]) begin
          tbl_live[sel] = 1'b0;
          pending_results.push_back(slot_result(EV_RETIRED, sel, 1'b1));
        end else begin
          pending_results.push_back(blank_result(EV_NOTFOUND, '0));
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  // scoreboard: predict on command accept, compare on result accept
  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      predict_results(s_axis_tuser, s_axis_tdata[23:0], s_axis_tdata[87:24],
                      s_axis_tdata[135:88], s_axis_tdata[140:136]);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, event %0d slot %0d", $time, m_axis_tuser,
                 m_axis_tdata[4:0]);
        err_count++;
      end else begin
        r = pending_results.pop_front();
        check_field("event_res", r.ev, m_axis_tuser);
        check_field("slot", r.slot, m_axis_tdata[4:0]);
        check_field("lid_out", r.lid, m_axis_tdata[28:5]);
        check_field("tid_out", r.tid, m_axis_tdata[92:29]);
        check_field("attempt", r.att, m_axis_tdata[100:93]);
        check_field("next_deadline", r.dl, m_axis_tdata[133:101]);
        check_field("last", r.last, m_axis_tlast);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_cmd(logic [2:0] fn, logic [23:0] lid, logic [63:0] tid,
                          logic [47:0] now, logic [4:0] sel);
    int g;
    g = draw_gap();
    @(negedge clk_i);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= {3'b000, sel, now, tid, lid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain_all();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    case (idx)
      REG_INIT_TMO: cfg_init_tmo = val[31:0];
      REG_LIMIT:    cfg_limit = val[7:0];
      REG_STEP:     cfg_step = val[31:0];
      REG_BUDGET:   cfg_budget = val[31:0];
      REG_SLACK:    cfg_slack = val[31:0];
      REG_MASK:     cfg_mask = val;
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_directed();
    // extremes, all functions, unmatched and ignored codes, empty scan
    send_cmd(FN_AGE, '0, '0, 48'd0, '0);
    send_cmd(FN_ALLOC, 24'hFFFFFF, '1, '1, 5'h1F);
    send_cmd(FN_ALLOC, 24'h000000, '0, 48'd0, '0);
    send_cmd(FN_ALLOC, 24'h123456, 64'hDEAD_BEEF_0123_4567, 48'd5, '0);
    send_cmd(FN_RESP, 24'h123456, 64'hDEAD_BEEF_0123_4566, 48'd6, '0);
    send_cmd(FN_RESP, 24'hFFFFFF, '1, 48'd7, '0);
    send_cmd(FN_ERR, 24'h000000, '0, 48'd8, '0);
    send_cmd(FN_ERR, 24'h000000, '0, 48'd9, '0);
    send_cmd(FN_ERR, 24'h999999, '0, 48'd9, '0);
    send_cmd(FN_RETIRE, '0, '0, 48'd10, 5'd31);
    send_cmd(FN_RETIRE, '0, '0, 48'd10, 5'd2);
    send_cmd(3'd5, '1, '1, '1, '1);
    send_cmd(3'd6, '0, '0, '0, '0);
    send_cmd(3'd7, '1, '0, '1, '0);
    send_cmd(FN_AGE, '0, '0, 48'd20, '0);
    send_cmd(FN_AGE, '0, '0, '1, '0);
    send_cmd(FN_AGE, '0, '0, 48'd30, '0);
    send_cmd(FN_RETIRE, '0, '0, 48'd31, 5'd0);
    drain_all();
  endtask

  task automatic test_random(int count);
    int          r;
    int          s;
    logic [2:0]  fn;
    logic [23:0] lid;
    logic [63:0] tid;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, NumSlots - 1);
      lid = ($urandom_range(0, 1) != 0) ? 24'($urandom_range(0, 3)) : 24'($urandom);
      tid = {$urandom, $urandom};
      cur_now = cur_now + 48'($urandom_range(0, 30));
      if ($urandom_range(0, 49) == 0) cur_now = {16'($urandom), $urandom};
      if (r < 35) begin
        fn = FN_ALLOC;
      end else if (r < 70) begin
        fn = (r < 55) ? FN_RESP : FN_ERR;
        // mostly aim at a live slot, with bits outside the mask scrambled
        if (tbl_live[s] && r % 4 != 0) begin
          lid = tbl_lid[s];
          tid = (tbl_tid[s] & cfg_mask) | (tid & ~cfg_mask);
        end
      end else if (r < 85) begin
        fn = FN_AGE;
      end else if (r < 95) begin
        fn = FN_RETIRE;
      end else begin
        fn = 3'($urandom_range(5, 7));
      end
      send_cmd(fn, lid, tid, cur_now, 5'(s));
    end
    drain_all();
  endtask

  task automatic test_pool_full();
    for (int n = 0; n < NumSlots + 2; n++)
      send_cmd(FN_ALLOC, 24'($urandom), {$urandom, $urandom}, cur_now, '0);
    send_cmd(FN_AGE, '0, '0, cur_now + 48'd3, '0);
    drain_all();
  endtask

  task automatic test_fixed_mode();
    cfg_write(REG_INIT_TMO, 64'd20);
    cfg_write(REG_LIMIT, 64'd0);
    cfg_write(REG_SLACK, 64'd5);
    test_random(40);
    cfg_write(REG_LIMIT, 64'd255);
    test_random(35);
  endtask

  task automatic test_stepped_mode();
    cfg_write(REG_STEP, 64'd10);
    cfg_write(REG_BUDGET, 64'd45);
    cfg_write(REG_LIMIT, 64'd2);
    cfg_write(REG_MASK, 64'h0000_0000_0000_FFFF);
    test_random(45);
    cfg_write(REG_STEP, 64'd1);
    cfg_write(REG_BUDGET, 64'd0);
    test_random(15);
  endtask

  task automatic test_extremes();
    cfg_write(REG_INIT_TMO, 64'hFFFF_FFFF);
    cfg_write(REG_STEP, 64'hFFFF_FFFF);
    cfg_write(REG_BUDGET, 64'hFFFF_FFFF);
    cfg_write(REG_SLACK, 64'hFFFF_FFFF);
    cfg_write(REG_MASK, 64'd0);
    test_random(30);
    cfg_write(REG_INIT_TMO, 64'd0);
    cfg_write(REG_STEP, 64'd0);
    cfg_write(REG_BUDGET, 64'd0);
    cfg_write(REG_SLACK, 64'd0);
    cfg_write(REG_MASK, '1);
    test_random(20);
  endtask

  initial begin
    for (int i = 0; i < NumSlots; i++) tbl_live[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(20);
    test_pool_full();
    test_fixed_mode();
    test_stepped_mode();
    test_extremes();
    // a stretch with the receiver always ready
    sink_busy = 1'b0;
    test_random(15);
    drain_all();
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/rrtt_pkg.sv
design/rrtt_cell.sv
design/rrtt_head.sv
design/request_retry_timeout_tracker.sv
design/rrtt_checker.sv
verif/tb_request_retry_timeout_tracker.sv
